>>> sv/assert_macros.svh
// Assertion macros shared by the tick divider RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that the antecedent implies the consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Check that the antecedent implies the consequent in the next cycle
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/mrtd_pkg.sv
// Package for the multi-rate tick divider: field widths, register indices,
// the switch phase period table and the phase cell configuration bundle.
`default_nettype none

package mrtd_pkg;

    // Fixed field widths
    localparam int MS_W     = 16;
    localparam int SEL_W    = 3;
    localparam int PHASE_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 3;

    // Register indices on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LINE_FREQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_EN  = 1'd1;

    // Reset values of the configuration registers
    localparam logic [SEL_W-1:0] LINE_FREQ_RESET = 3'd1;
    localparam logic             PHASE_EN_RESET  = 1'b1;

    // Half-period table of the switch phase, one-based selector
    localparam int PERIOD_ENTRIES = 6;
    localparam logic [PHASE_W-1:0] PERIOD_TABLE [PERIOD_ENTRIES] =
        '{5'd0, 5'd1, 5'd3, 5'd7, 5'd19, 5'd19};

    // Configuration seen by the phase cell
    typedef struct packed {
        logic             enable;
        logic [SEL_W-1:0] line_freq_sel;
    } phase_cfg_t;

    // Look up the period, clamping the selector into 1..6
    function automatic logic [PHASE_W-1:0] period_of(input logic [SEL_W-1:0] sel);
        logic [SEL_W-1:0] idx;
        if (sel == 3'd0) begin
            idx = 3'd0;
        end
        else if (sel == 3'd7) begin
            idx = 3'd5;
        end
        else begin
            idx = sel - 3'd1;
        end
        return PERIOD_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

>>> sv/mrtd_div_cell.sv
// One divider cell of the strobe chain: a modulo counter that advances on its
// carry in and raises carry out on wrap. Uses mrtd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mrtd_div_cell #(
    parameter int MODULUS = 10,
    parameter int CNT_W   = (MODULUS > 1) ? $clog2(MODULUS) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             carry_in,
    output logic                  carry_out,
    output logic [CNT_W-1:0]      count,
    output logic [CNT_W-1:0]      count_next
);
    import mrtd_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(MODULUS - 1);

    logic [CNT_W-1:0] count_reg;

    // Wrap on the last value when the parent strobes
    assign carry_out = carry_in && (count_reg == LAST);

    always_comb
    begin
        if (!carry_in) begin
            count_next = count_reg;
        end
        else if (carry_out) begin
            count_next = '0;
        end
        else begin
            count_next = count_reg + 1'b1;
        end
    end

    // Advance the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

    `ASSERT_IMP(a_carry_needs_parent, clk, rst_n, carry_out, carry_in)
    `ASSERT_IMP(a_count_in_range, clk, rst_n, 1'b1, count_reg <= LAST)
    `ASSERT_NXT(a_hold_without_parent, clk, rst_n, !carry_in, $stable(count_reg))

endmodule

`default_nettype wire

>>> sv/mrtd_phase_cell.sv
// Switch phase cell: square wave whose high phase lasts period+1 ticks and low
// phase max(period,1) ticks. Uses mrtd_pkg for the period table and config type.
`default_nettype none

module mrtd_phase_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire mrtd_pkg::phase_cfg_t cfg,
    output logic                    sample
);
    import mrtd_pkg::*;

    logic               high_reg;
    logic               high_next;
    logic [PHASE_W-1:0] count_reg;
    logic [PHASE_W-1:0] count_next;
    logic [PHASE_W-1:0] count_inc;
    logic [PHASE_W-1:0] period;

    assign period    = period_of(cfg.line_freq_sel);
    assign count_inc = count_reg + 1'b1;

    // Sample is the phase level before this tick moves it, low while disabled
    assign sample = cfg.enable && high_reg;

    // Step the phase; hold it while disabled
    always_comb
    begin
        high_next  = high_reg;
        count_next = count_reg;
        if (advance && cfg.enable) begin
            if (high_reg) begin
                if (count_inc > period) begin
                    count_next = '0;
                    high_next  = 1'b0;
                end
                else begin
                    count_next = count_inc;
                end
            end
            else begin
                if (count_inc >= period) begin
                    count_next = '0;
                    high_next  = 1'b1;
                end
                else begin
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            high_reg  <= 1'b1;
            count_reg <= '0;
        end
        else begin
            high_reg  <= high_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/multi_rate_tick_divider_unit.sv
// Top level of the multi-rate tick divider: phase cell, divider cell chain,
// elapsed-time subtractor and output register. Uses mrtd_pkg and the cells.
`default_nettype none
`include "assert_macros.svh"

// Each accepted transaction is one tick and yields exactly one result in the
// next cycle; a new tick is taken every cycle, including while a result is
// waiting, as long as the output register is free or being drained in the same
// cycle. The divider chain is combinational: eight counter cells ripple their
// strobes through, followed by one 16-bit compare and subtract for the elapsed
// time. start_stamp values above MS_WRAP are treated as MS_WRAP. The
// configuration registers act from the next tick.
module multi_rate_tick_divider_unit #(
    parameter int TICKS_PER_MS = 8,
    parameter int MS_WRAP      = 60000
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port
    input  wire logic                          cfg_write,
    input  wire logic [mrtd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mrtd_pkg::CFG_DATA_W-1:0] cfg_data,
    // Tick input
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mrtd_pkg::MS_W-1:0]     start_stamp,
    // Result output
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               sample_window,
    output logic                               strobe_1ms,
    output logic                               strobe_6ms,
    output logic                               strobe_10ms,
    output logic                               strobe_100ms,
    output logic                               strobe_300ms,
    output logic                               strobe_500ms,
    output logic                               strobe_1s,
    output logic [mrtd_pkg::MS_W-1:0]          ms_now,
    output logic [mrtd_pkg::MS_W-1:0]          elapsed_ms
);
    import mrtd_pkg::*;

    localparam int MS_CNT_W = $clog2(MS_WRAP + 1);
    localparam logic [MS_W-1:0] WRAP = MS_W'(MS_WRAP);

    // Configuration registers
    logic [SEL_W-1:0] line_freq_sel_reg;
    logic             phase_en_reg;
    phase_cfg_t       phase_cfg;

    // Handshake
    logic accept;
    logic out_valid_reg;

    // Chain signals
    logic sample_now;
    logic s1, s6, s10, s100, s300, s500, s1s;
    logic [MS_CNT_W-1:0] ms_count;
    logic [MS_CNT_W-1:0] ms_count_next;
    logic [MS_W-1:0]     ms_after;
    logic [MS_W-1:0]     start_sat;
    logic [MS_W-1:0]     elapsed_next;

    // Output payload registers
    logic            sample_reg;
    logic            s1_reg, s6_reg, s10_reg, s100_reg, s300_reg, s500_reg, s1s_reg;
    logic [MS_W-1:0] elapsed_reg;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_freq_sel_reg <= LINE_FREQ_RESET;
            phase_en_reg      <= PHASE_EN_RESET;
        end
        else if (cfg_write) begin
            case (cfg_index)
                REG_LINE_FREQ: line_freq_sel_reg <= cfg_data;
                REG_PHASE_EN:  phase_en_reg      <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign phase_cfg.enable        = phase_en_reg;
    assign phase_cfg.line_freq_sel = line_freq_sel_reg;

    // Take a tick whenever the output register is empty or draining
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    mrtd_phase_cell u_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .cfg     (phase_cfg),
        .sample  (sample_now)
    );

    // Divider chain: tick -> 1 ms -> {6 ms, ms counter, 10 ms -> 100 ms -> ...}
    mrtd_div_cell #(.MODULUS(TICKS_PER_MS)) u_tick (
        .clk (clk), .rst_n (rst_n), .carry_in (accept), .carry_out (s1),
        .count (), .count_next ()
    );

    mrtd_div_cell #(.MODULUS(MS_WRAP + 1)) u_ms (
        .clk (clk), .rst_n (rst_n), .carry_in (s1), .carry_out (),
        .count (ms_count), .count_next (ms_count_next)
    );

    mrtd_div_cell #(.MODULUS(6)) u_six (
        .clk (clk), .rst_n (rst_n), .carry_in (s1), .carry_out (s6),
        .count (), .count_next ()
    );

    mrtd_div_cell #(.MODULUS(10)) u_ten (
        .clk (clk), .rst_n (rst_n), .carry_in (s1), .carry_out (s10),
        .count (), .count_next ()
    );

    mrtd_div_cell #(.MODULUS(10)) u_hundred (
        .clk (clk), .rst_n (rst_n), .carry_in (s10), .carry_out (s100),
        .count (), .count_next ()
    );

    mrtd_div_cell #(.MODULUS(3)) u_three (
        .clk (clk), .rst_n (rst_n), .carry_in (s100), .carry_out (s300),
        .count (), .count_next ()
    );

    mrtd_div_cell #(.MODULUS(5)) u_five (
        .clk (clk), .rst_n (rst_n), .carry_in (s100), .carry_out (s500),
        .count (), .count_next ()
    );

    mrtd_div_cell #(.MODULUS(2)) u_two (
        .clk (clk), .rst_n (rst_n), .carry_in (s500), .carry_out (s1s),
        .count (), .count_next ()
    );

    // Elapsed time from the saturated start stamp, wrapping around MS_WRAP
    assign ms_after  = MS_W'(ms_count_next);
    assign start_sat = (start_stamp > WRAP) ? WRAP : start_stamp;

    always_comb
    begin
        if (ms_after >= start_sat) begin
            elapsed_next = ms_after - start_sat;
        end
        else begin
            elapsed_next = WRAP - start_sat + ms_after;
        end
    end

    // Hold the result until the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (accept) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the payload on each accepted tick
    always_ff @(posedge clk)
    begin
        if (accept) begin
            sample_reg  <= sample_now;
            s1_reg      <= s1;
            s6_reg      <= s6;
            s10_reg     <= s10;
            s100_reg    <= s100;
            s300_reg    <= s300;
            s500_reg    <= s500;
            s1s_reg     <= s1s;
            elapsed_reg <= elapsed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_window = sample_reg;
    assign strobe_1ms    = s1_reg;
    assign strobe_6ms    = s6_reg;
    assign strobe_10ms   = s10_reg;
    assign strobe_100ms  = s100_reg;
    assign strobe_300ms  = s300_reg;
    assign strobe_500ms  = s500_reg;
    assign strobe_1s     = s1s_reg;
    // The ms counter only moves on an accepted tick, together with the payload
    assign ms_now        = MS_W'(ms_count);
    assign elapsed_ms    = elapsed_reg;

    `ASSERT_IMP(a_1s_nested, clk, rst_n, out_valid && strobe_1s, strobe_500ms && strobe_100ms)
    `ASSERT_IMP(a_6ms_parent, clk, rst_n, out_valid && strobe_6ms, strobe_1ms)
    `ASSERT_IMP(a_elapsed_range, clk, rst_n, out_valid, elapsed_ms <= WRAP && ms_now <= WRAP)

endmodule

`default_nettype wire

>>> tb/multi_rate_tick_divider_unit_test.sv
// Self-checking testbench for multi_rate_tick_divider_unit.
// Drives 125 us ticks, predicts every strobe and counter, and checks each result.
// Depends on mrtd_pkg and the unit RTL only.
`timescale 1ns / 1ps

module multi_rate_tick_divider_unit_test;

    import mrtd_pkg::*;

    localparam int TICKS_PER_MS = 8;
    localparam int MS_WRAP      = 60000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 64;
    localparam int PHASE_PERIODS [6] = '{0, 1, 3, 7, 19, 19};
    localparam logic [MS_W-1:0] EDGE_STAMPS [8] =
        '{16'd0, 16'hFFFF, 16'd60000, 16'd60001, 16'd1, 16'h5555, 16'hAAAA, 16'd59999};

    typedef struct packed {
        logic            sample_window;
        logic            strobe_1ms;
        logic            strobe_6ms;
        logic            strobe_10ms;
        logic            strobe_100ms;
        logic            strobe_300ms;
        logic            strobe_500ms;
        logic            strobe_1s;
        logic [MS_W-1:0] ms_now;
        logic [MS_W-1:0] elapsed_ms;
    } tick_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_LINE_FREQ;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [MS_W-1:0]       start_stamp = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  sample_window;
    logic                  strobe_1ms;
    logic                  strobe_6ms;
    logic                  strobe_10ms;
    logic                  strobe_100ms;
    logic                  strobe_300ms;
    logic                  strobe_500ms;
    logic                  strobe_1s;
    logic [MS_W-1:0]       ms_now;
    logic [MS_W-1:0]       elapsed_ms;

    // Stimulus pacing and bookkeeping
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    logic         hold_request = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  cycle_count = 0;
    int unsigned  mismatch_count = 0;
    tick_result_t pending_results [$];

    // Predicted register and counter state
    logic [SEL_W-1:0]   m_line_sel = LINE_FREQ_RESET;
    logic               m_phase_en = PHASE_EN_RESET;
    logic [2:0]         m_tick_cnt = '0;
    logic               m_phase_high = 1'b1;
    logic [PHASE_W-1:0] m_phase_cnt = '0;
    logic [MS_W-1:0]    m_ms = '0;
    logic [2:0]         m_six_cnt = '0;
    logic [3:0]         m_ten_cnt = '0;
    logic [3:0]         m_hund_cnt = '0;
    logic [1:0]         m_three_cnt = '0;
    logic [2:0]         m_five_cnt = '0;
    logic               m_two_cnt = 1'b0;

    multi_rate_tick_divider_unit #(
        .TICKS_PER_MS (TICKS_PER_MS),
        .MS_WRAP      (MS_WRAP)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_stamp   (start_stamp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_window (sample_window),
        .strobe_1ms    (strobe_1ms),
        .strobe_6ms    (strobe_6ms),
        .strobe_10ms   (strobe_10ms),
        .strobe_100ms  (strobe_100ms),
        .strobe_300ms  (strobe_300ms),
        .strobe_500ms  (strobe_500ms),
        .strobe_1s     (strobe_1s),
        .ms_now        (ms_now),
        .elapsed_ms    (elapsed_ms)
    );

    always #6 clk = ~clk;

    // Advance the predicted divider chain by one tick and return its outputs
    function automatic tick_result_t predict_tick_outputs(input logic [MS_W-1:0] stamp);
        tick_result_t r;
        int sel;
        int period;
        int ph;
        int t;
        int nxt;
        int start;
        r = '0;
        // Switch phase: high lasts period+1 ticks, low lasts max(period,1) ticks
        if (m_phase_en) begin
            sel = int'(m_line_sel);
            if (sel < 1) sel = 1;
            if (sel > 6) sel = 6;
            period = PHASE_PERIODS[sel-1];
            ph = int'(m_phase_cnt) + 1;
            if (m_phase_high) begin
                r.sample_window = 1'b1;
                if (ph > period) begin
                    ph = 0;
                    m_phase_high = 1'b0;
                end
            end
            else if (ph >= period) begin
                ph = 0;
                m_phase_high = 1'b1;
            end
            m_phase_cnt = PHASE_W'(ph);
        end
        // Millisecond prescaler and the cascaded dividers behind it
        t = int'(m_tick_cnt) + 1;
        if (t >= TICKS_PER_MS) begin
            t = 0;
            r.strobe_1ms = 1'b1;
            nxt = int'(m_ms) + 1;
            if (nxt > MS_WRAP) nxt = 0;
            m_ms = MS_W'(nxt);
            if (m_six_cnt >= 3'd5) begin
                m_six_cnt = '0;
                r.strobe_6ms = 1'b1;
            end
            else begin
                m_six_cnt = m_six_cnt + 3'd1;
            end
            nxt = int'(m_ten_cnt) + 1;
            if (nxt >= 10) begin
                nxt = 0;
                r.strobe_10ms = 1'b1;
                m_hund_cnt = m_hund_cnt + 4'd1;
                if (m_hund_cnt >= 4'd10) begin
                    m_hund_cnt = '0;
                    r.strobe_100ms = 1'b1;
                    if (int'(m_three_cnt) + 1 >= 3) begin
                        m_three_cnt = '0;
                        r.strobe_300ms = 1'b1;
                    end
                    else begin
                        m_three_cnt = m_three_cnt + 2'd1;
                    end
                    if (int'(m_five_cnt) + 1 >= 5) begin
                        m_five_cnt = '0;
                        r.strobe_500ms = 1'b1;
                        if (int'(m_two_cnt) + 1 >= 2) begin
                            m_two_cnt = 1'b0;
                            r.strobe_1s = 1'b1;
                        end
                        else begin
                            m_two_cnt = 1'b1;
                        end
                    end
                    else begin
                        m_five_cnt = m_five_cnt + 3'd1;
                    end
                end
            end
            m_ten_cnt = 4'(nxt);
        end
        m_tick_cnt = 3'(t);
        // Elapsed time, saturating the stamp and wrapping round the minute
        start = int'(stamp);
        if (start > MS_WRAP) start = MS_WRAP;
        r.ms_now = m_ms;
        if (int'(m_ms) >= start) r.elapsed_ms = MS_W'(int'(m_ms) - start);
        else r.elapsed_ms = MS_W'(MS_WRAP - start + int'(m_ms));
        return r;
    endfunction

    // Draw a stamp: mostly in range, some near the counter, some above the wrap
    function automatic logic [MS_W-1:0] pick_stamp();
        int unsigned roll;
        int v;
        roll = $urandom_range(99);
        if (roll < 60) return MS_W'($urandom_range(MS_WRAP, 0));
        if (roll < 80) begin
            v = int'(m_ms) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > MS_WRAP) v = MS_WRAP;
            return MS_W'(v);
        end
        return MS_W'($urandom_range(16'hFFFF, 0));
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Offer one tick, hold it until taken, then record the expected result
    task automatic send_tick(input logic [MS_W-1:0] stamp);
        tick_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_stamp <= stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = predict_tick_outputs(stamp);
        pending_results.push_back(r);
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Write both registers while the unit is idle
    task automatic set_config(input logic [SEL_W-1:0] sel, input logic enable);
        cfg_write <= 1'b1;
        cfg_index <= REG_LINE_FREQ;
        cfg_data  <= CFG_DATA_W'(sel);
        @(posedge clk);
        cfg_index <= REG_PHASE_EN;
        cfg_data  <= CFG_DATA_W'(enable);
        @(posedge clk);
        cfg_write <= 1'b0;
        m_line_sel = sel;
        m_phase_en = enable;
    endtask

    // Reset values: selector one gives a zero period, phase generator on
    task automatic test_reset_defaults();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (EDGE_STAMPS[i]) send_tick(EDGE_STAMPS[i]);
        wait_for_results();
    endtask

    // Phase generator off: sample_window stays low and the phase holds
    task automatic test_phase_disabled();
        set_config(3'd4, 1'b0);
        repeat (6) send_tick(pick_stamp());
        wait_for_results();
    endtask

    // Selector outside 1..6 clamps to the nearest table entry
    task automatic test_selector_clamp();
        set_config(3'd0, 1'b1);
        repeat (4) send_tick(pick_stamp());
        wait_for_results();
        set_config(3'd7, 1'b1);
        repeat (4) send_tick(pick_stamp());
        wait_for_results();
    endtask

    // Random stamps under three pacing modes, reconfiguring between batches
    task automatic test_random_traffic();
        int unsigned batch;
        batch = 0;
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 80 : 0;
            recv_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 32 : 0;
            for (int b = 0; b < 5; b++) begin
                set_config(SEL_W'((batch * 3 + 1) % 8), (batch % 4) != 3);
                repeat (100) send_tick(pick_stamp());
                wait_for_results();
                batch++;
            end
        end
    endtask

    // Hold the output off for a long stretch while ticks keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(3'd3, 1'b1);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        repeat (24) send_tick(pick_stamp());
        wait_for_results();
    endtask

    // Steady stream on the longest period, carrying the cascade past 200 ms
    task automatic test_strobe_cascade();
        send_idle_pct = 0;
        recv_idle_pct = 10;
        set_config(3'd6, 1'b1);
        repeat (100) send_tick(pick_stamp());
        wait_for_results();
    endtask

    // Receiver pacing: a requested long hold, otherwise random stalls
    always @(posedge clk) begin
        if (hold_request && hold_left == 0) hold_left = LONG_HOLD;
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk) begin
        tick_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual ms_now %0d",
                         $time, ms_now);
            end
            else begin
                want = pending_results.pop_front();
                check_field("sample_window", want.sample_window, sample_window);
                check_field("strobe_1ms", want.strobe_1ms, strobe_1ms);
                check_field("strobe_6ms", want.strobe_6ms, strobe_6ms);
                check_field("strobe_10ms", want.strobe_10ms, strobe_10ms);
                check_field("strobe_100ms", want.strobe_100ms, strobe_100ms);
                check_field("strobe_300ms", want.strobe_300ms, strobe_300ms);
                check_field("strobe_500ms", want.strobe_500ms, strobe_500ms);
                check_field("strobe_1s", want.strobe_1s, strobe_1s);
                check_field("ms_now", want.ms_now, ms_now);
                check_field("elapsed_ms", want.elapsed_ms, elapsed_ms);
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_phase_disabled();
        test_selector_clamp();
        test_random_traffic();
        test_output_backpressure();
        test_strobe_cascade();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end
        else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
